// ===== src/llr_pkg.sv =====
// Shared constants and controller/datapath interface types for the line resampler.
package llr_pkg;

  // Width of each configuration register (UQ8.16).
  localparam int REG_W = 24;
  // Fraction bits of grid positions.
  localparam int FRAC_BITS = 16;
  // Grid position register: one bit above a register covers position plus step.
  localparam int POS_W = REG_W + 1;
  // Most results one input beat may cause.
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  // Default sample width.
  localparam int DEF_SAMPLE_BITS = 24;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_START = 1'b0;
  localparam logic REG_STEP = 1'b1;
  localparam logic [REG_W-1:0] RESET_START = '0;
  localparam logic [REG_W-1:0] RESET_STEP = REG_W'(1) << FRAC_BITS;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // take an input beat
    logic issue;     // multiply for the next grid point and advance the position
    logic emit_pt;   // load the output register with an interpolated point
    logic emit_end;  // load the output register with the sample itself, end the line
    logic finish;    // close the segment without an end point
  } llr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic started;    // a line is in progress
    logic in_last;    // the offered input beat ends the line
    logic start_zero; // start position register is zero
    logic more;       // another grid point lies in the current segment
    logic fin_end;    // a point lies exactly on the closing sample of the line
    logic out_free;   // the output register can take a beat
  } llr_status_t;

endpackage

// ===== src/llr_regs.sv =====
// APB configuration registers for the line resampler.
module llr_regs
  import llr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [REG_W-1:0]      start_o,
  output logic [REG_W-1:0]      step_o
);

  logic [REG_W-1:0] start_q, step_q;
  logic             wr_en;
  logic             reg_sel;

  // Registers sit at byte addresses 0 and 4.
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= RESET_START;
      step_q  <= RESET_STEP;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_START: start_q <= pwdata[REG_W-1:0];
        REG_STEP:  step_q  <= pwdata[REG_W-1:0];
        default:   ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    unique case (reg_sel)
      REG_START: prdata = APB_DATA_W'(start_q);
      REG_STEP:  prdata = APB_DATA_W'(step_q);
      default:   prdata = '0;
    endcase
  end

  assign start_o = start_q;
  assign step_o  = step_q;

endmodule

// ===== src/llr_dp.sv =====
// Datapath of the line resampler: line state, interpolation multiplier and output register.
module llr_dp
  import llr_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  llr_cmd_t               cmd_i,
  output llr_status_t            status_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   line_end_i,
  input  logic [REG_W-1:0]       start_i,
  input  logic [REG_W-1:0]       step_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [SAMPLE_BITS-1:0] value_o,
  output logic                   run_last_o,
  output logic                   line_last_o
);

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam logic [POS_W-1:0]  ONE_POS    = POS_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_RESULTS);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  // Line state.
  logic                   started_q;
  logic [POS_W-1:0]       pos_q;
  logic [SAMPLE_BITS-1:0] prev_q;
  logic                   last_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   rl_q;
  // Payload of the item at work.
  logic [SAMPLE_BITS-1:0] cur_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [PROD_W-1:0] prod_q;
  // Output register.
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_value_q;
  logic                   out_rl_q;
  logic                   out_ll_q;

  logic signed [DIFF_W-1:0] diff_d;
  logic signed [FRAC_BITS:0] frac_s;
  logic signed [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0]        biased;
  logic signed [PROD_W-1:0] scaled;
  logic [SAMPLE_BITS-1:0]   value_d;
  logic [POS_W-1:0]         pos_inc;
  logic [POS_W-1:0]         pos_fin;
  logic [CNT_W-1:0]         cnt_inc;
  logic                     more_next;
  logic                     endpt_next;
  logic                     out_free;

  // Segment difference and product of difference and fractional position.
  assign diff_d = $signed({sample_i[SAMPLE_BITS-1], sample_i})
                - $signed({prev_q[SAMPLE_BITS-1], prev_q});
  assign frac_s = $signed({1'b0, pos_q[FRAC_BITS-1:0]});
  assign prod_d = diff_q * frac_s;

  // Round to nearest with ties upward: add half, then floor by arithmetic shift.
  assign biased  = prod_q + ROUND_HALF;
  assign scaled  = $signed(biased) >>> FRAC_BITS;
  assign value_d = prev_q + scaled[SAMPLE_BITS-1:0];

  // Next grid point, and whether another result of this input follows it.
  assign pos_inc    = pos_q + POS_W'(step_i);
  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign more_next  = (pos_inc < ONE_POS) && (cnt_inc < MAX_CNT);
  assign endpt_next = last_q && (pos_inc <= ONE_POS) && (cnt_inc < MAX_CNT);
  // Position relative to the new sample once the segment is closed.
  assign pos_fin    = (pos_q < ONE_POS) ? '0 : pos_q - ONE_POS;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    status_o.started    = started_q;
    status_o.in_last    = line_end_i;
    status_o.start_zero = (start_i == '0);
    status_o.more       = (pos_q < ONE_POS) && (cnt_q < MAX_CNT);
    status_o.fin_end    = last_q && (pos_q <= ONE_POS) && (cnt_q < MAX_CNT);
    status_o.out_free   = out_free;
  end

  // Line state and per-item control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      pos_q     <= '0;
      prev_q    <= '0;
      last_q    <= 1'b0;
      cnt_q     <= '0;
      rl_q      <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        cnt_q  <= '0;
        last_q <= line_end_i;
        if (!started_q) begin
          if (line_end_i && (start_i != '0)) begin
            // A one-sample line with an offset grid gives nothing.
            started_q <= 1'b0;
            pos_q     <= '0;
            prev_q    <= '0;
          end else begin
            started_q <= 1'b1;
            pos_q     <= POS_W'(start_i);
            prev_q    <= sample_i;
          end
        end
      end
      if (cmd_i.issue) begin
        pos_q <= pos_inc;
        cnt_q <= cnt_inc;
        rl_q  <= !more_next && !endpt_next;
      end
      if (cmd_i.finish) begin
        if (last_q) begin
          started_q <= 1'b0;
          pos_q     <= '0;
          prev_q    <= '0;
        end else begin
          pos_q  <= pos_fin;
          prev_q <= cur_q;
        end
      end
      if (cmd_i.emit_end) begin
        started_q <= 1'b0;
        pos_q     <= '0;
        prev_q    <= '0;
      end
    end
  end

  // Item payload and multiplier output.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q  <= sample_i;
      diff_q <= diff_d;
    end
    if (cmd_i.issue) begin
      prod_q <= prod_d;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_pt || cmd_i.emit_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pt) begin
      out_value_q <= value_d;
      out_rl_q    <= rl_q;
      out_ll_q    <= rl_q && last_q;
    end else if (cmd_i.emit_end) begin
      out_value_q <= cur_q;
      out_rl_q    <= 1'b1;
      out_ll_q    <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign run_last_o  = out_rl_q;
  assign line_last_o = out_ll_q;

endmodule

// ===== src/llr_ctrl.sv =====
// Controller state machine of the line resampler.
module llr_ctrl
  import llr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  llr_status_t status_i,
  output llr_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.started) begin
            state_d = S_MUL;
          end else if (status_i.in_last && status_i.start_zero) begin
            state_d = S_END;
          end
        end
      end
      S_MUL: begin
        if (status_i.more) begin
          cmd_o.issue = 1'b1;
          state_d     = S_EMIT;
        end else if (status_i.fin_end) begin
          state_d = S_END;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_pt = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_END: begin
        if (status_i.out_free) begin
          cmd_o.emit_end = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/linear_line_resampler.sv =====
// Top level of the linear line resampler.
//
// Channel   Direction  tdata             tuser     tlast
// s_axis    in         sample            -         line_end
// m_axis    out        value             run_last  line_last
// apb       in/out     start_position @0x0, position_step @0x4
//
// A sample is accepted in S_IDLE. Each interpolated result is multiplied
// in S_MUL and loaded into the output register in S_EMIT, the end point of
// a line in S_END; S_MUL then closes the segment. A line's first sample only
// sets up the line, or goes to S_END if it alone is a line ending on its own
// point. The output register holds one beat, so a stalled output holds the
// controller only at its next result. Reset is asynchronous and clears the
// line state and loads the register defaults.
module linear_line_resampler
  import llr_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // [SAMPLE_BITS-1:0] sample
  input  logic                  s_axis_tlast,                // line_end
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata, // [SAMPLE_BITS-1:0] value
  output logic                  m_axis_tuser,                // run_last
  output logic                  m_axis_tlast,                // line_last
  // Configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  logic [REG_W-1:0]       start_pos;
  logic [REG_W-1:0]       pos_step;
  llr_cmd_t               cmd;
  llr_status_t            status;
  logic [SAMPLE_BITS-1:0] value;

  llr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start_o (start_pos),
    .step_o  (pos_step)
  );

  llr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  llr_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .line_end_i  (s_axis_tlast),
    .start_i     (start_pos),
    .step_i      (pos_step),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .value_o     (value),
    .run_last_o  (m_axis_tuser),
    .line_last_o (m_axis_tlast)
  );

  // Zero padding up to whole bytes.
  assign m_axis_tdata = TDATA_W'($unsigned(value));

endmodule

// ===== src/llr_checker.sv =====
// Port-level checks of the linear line resampler and their binding.
module llr_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
  input logic                                 m_axis_tuser,
  input logic                                 m_axis_tlast,
  input logic                                 pready
);

  // A stalled output beat keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // The last beat of a line is also the last beat of its sample.
  a_line_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("line_last without run_last");

  // While more results of a sample are due, no new sample is taken.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> !s_axis_tready)
    else $error("input ready in the middle of a run");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind linear_line_resampler llr_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_llr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);
